// ----- src/sfc_pkg.sv -----
// shared types and constants for the sphere frustum cull test
package sfc_pkg;

    localparam int NUM_PLANES_DEF = 6;
    localparam int COEF_W         = 32;
    localparam int RAD_W          = 31;
    localparam int IDX_W          = 3;
    localparam int PROD_W         = 2 * COEF_W;
    // three products plus the scaled offset and radius never leave 66 signed bits
    localparam int SUM_W          = PROD_W + 2;
    localparam int DR_W           = COEF_W + 1;
    localparam int FRAC_W         = 16;
    localparam int CMP_W          = 5;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TEST = 1'b1;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] d;
    } plane_t;

endpackage

// ----- src/sphere_frustum_cull_test.sv -----
// a test word passes the input register, the product registers and the result register in order
// throughput: one word per cycle while out_ready is high, limited by the multiply and sum stages
// a load word writes its plane at the accepting edge and gives no result
// loads take effect for every test word accepted after them
// reset clears all planes to zero (every test then reports inside) and empties the pipeline
module sphere_frustum_cull_test
#(
    parameter int NUM_PLANES = sfc_pkg::NUM_PLANES_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic        [sfc_pkg::IDX_W-1:0]    plane_index,
    input  logic signed [sfc_pkg::COEF_W-1:0]   coef_a,
    input  logic signed [sfc_pkg::COEF_W-1:0]   coef_b,
    input  logic signed [sfc_pkg::COEF_W-1:0]   coef_c,
    input  logic signed [sfc_pkg::COEF_W-1:0]   coef_d,
    input  logic signed [sfc_pkg::COEF_W-1:0]   center_x,
    input  logic signed [sfc_pkg::COEF_W-1:0]   center_y,
    input  logic signed [sfc_pkg::COEF_W-1:0]   center_z,
    input  logic        [sfc_pkg::RAD_W-1:0]    radius,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                inside_res
);

    sfc_pkg::plane_t                   plane_store_reg [NUM_PLANES];
    sfc_pkg::plane_t                   load_plane;

    logic                              in_acc;
    logic                              a_ready;
    logic                              b_ready;
    logic                              c_ready;
    logic                              b_en;

    logic                              a_valid_reg;
    logic signed [sfc_pkg::COEF_W-1:0] cx_reg;
    logic signed [sfc_pkg::COEF_W-1:0] cy_reg;
    logic signed [sfc_pkg::COEF_W-1:0] cz_reg;
    logic        [sfc_pkg::RAD_W-1:0]  rad_reg;
    logic                              b_valid_reg;
    logic                              out_valid_reg;
    logic                              inside_reg;
    logic                              inside_next;
    logic        [NUM_PLANES-1:0]      behind;

    // each stage moves when the one after it is empty or moving
    assign c_ready  = !out_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;
    assign in_acc   = in_valid && in_ready;
    assign b_en     = a_valid_reg && b_ready;

    assign load_plane = '{a: coef_a, b: coef_b, c: coef_c, d: coef_d};

    // plane store, loads out of range fall through untouched
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                plane_store_reg[p] <= '0;
            end
        end
        else
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                if (in_acc && action == sfc_pkg::ACT_LOAD
                    && sfc_pkg::CMP_W'(plane_index) == sfc_pkg::CMP_W'(p))
                begin
                    plane_store_reg[p] <= load_plane;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_acc && action == sfc_pkg::ACT_TEST;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && action == sfc_pkg::ACT_TEST)
        begin
            cx_reg  <= center_x;
            cy_reg  <= center_y;
            cz_reg  <= center_z;
            rad_reg <= radius;
        end
        if (c_ready && b_valid_reg)
        begin
            inside_reg <= inside_next;
        end
    end

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        sfc_plane_eval u_eval
        (
            .clk      (clk),
            .en       (b_en),
            .plane    (plane_store_reg[p]),
            .center_x (cx_reg),
            .center_y (cy_reg),
            .center_z (cz_reg),
            .radius   (rad_reg),
            .behind   (behind[p])
        );
    end

    assign inside_next = !(|behind);
    assign out_valid   = out_valid_reg;
    assign inside_res  = inside_reg;

`ifndef SYNTH
    // input only stalls when every stage holds a word
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> a_valid_reg && b_valid_reg && out_valid_reg)
        else $error("input stalled with a free pipeline slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && b_ready |=> b_valid_reg)
        else $error("test word lost between input and product stages");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(b_valid_reg))
        else $error("result shown without a word in the product stage");
`endif

endmodule

// ----- src/sfc_plane_eval.sv -----
// one plane lane: registered products, then signed distance plus radius sign check
module sfc_plane_eval
(
    input  logic                                clk,
    input  logic                                en,
    input  sfc_pkg::plane_t                     plane,
    input  logic signed [sfc_pkg::COEF_W-1:0]   center_x,
    input  logic signed [sfc_pkg::COEF_W-1:0]   center_y,
    input  logic signed [sfc_pkg::COEF_W-1:0]   center_z,
    input  logic        [sfc_pkg::RAD_W-1:0]    radius,
    output logic                                behind
);

    logic signed [sfc_pkg::PROD_W-1:0] px_next;
    logic signed [sfc_pkg::PROD_W-1:0] py_next;
    logic signed [sfc_pkg::PROD_W-1:0] pz_next;
    logic signed [sfc_pkg::DR_W-1:0]   dr_next;
    logic signed [sfc_pkg::PROD_W-1:0] px_reg;
    logic signed [sfc_pkg::PROD_W-1:0] py_reg;
    logic signed [sfc_pkg::PROD_W-1:0] pz_reg;
    logic signed [sfc_pkg::DR_W-1:0]   dr_reg;
    logic signed [sfc_pkg::SUM_W-1:0]  dist_sum;

    assign px_next = plane.a * center_x;
    assign py_next = plane.b * center_y;
    assign pz_next = plane.c * center_z;
    // offset and radius share the same Q16.16 scale, so add them before scaling
    assign dr_next = sfc_pkg::DR_W'(plane.d) + $signed({2'b00, radius});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
            dr_reg <= dr_next;
        end
    end

    assign dist_sum = sfc_pkg::SUM_W'(px_reg) + sfc_pkg::SUM_W'(py_reg)
                    + sfc_pkg::SUM_W'(pz_reg)
                    + (sfc_pkg::SUM_W'(dr_reg) <<< sfc_pkg::FRAC_W);

    assign behind = dist_sum[sfc_pkg::SUM_W-1];

endmodule
